[hdl/stpe_pkg.sv]
// shared types and constants for the stepper trapezoid pulse engine
package stpe_pkg;

    localparam int FRACTION_BITS_DEF = 24;
    localparam int SPEED_W           = 25;
    localparam int POS_W             = 32;
    localparam int RATE_W            = 24;
    localparam int DIST_W            = 31;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 31;

    localparam logic [RATE_W-1:0] ACCEL_RESET     = 24'd1;
    localparam logic [RATE_W-1:0] MAX_SPEED_RESET = 24'd16777;
    localparam logic [DIST_W-1:0] ACCEL_DIST_RESET = 31'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_PER_TICK     = 2'd0,
        CFG_MAX_SPEED_PER_TICK = 2'd1,
        CFG_ACCEL_DISTANCE     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [RATE_W-1:0] accel_per_tick;
        logic [RATE_W-1:0] max_speed_per_tick;
        logic [DIST_W-1:0] accel_distance;
    } cfg_t;

    typedef struct packed {
        logic             step_pulse;
        logic             direction;
        logic [POS_W-1:0] position;
        logic             moving;
    } step_result_t;

endpackage

[hdl/stepper_trapezoid_pulse_engine_top.sv]
// top level: config registers, motion core and result register
//
// Step/direction generator with a trapezoidal ramp. A start request
// (kind 1) latches a signed target; each tick request (kind 0) short of the
// goal updates the speed and the fraction accumulator and may emit one step.
// Every request gives exactly one result, registered in the cycle after its
// acceptance; a new request is taken every cycle while the result register
// is empty or being drained in the same cycle, so throughput is one request
// per clock. Configuration writes take effect on the next clock and should
// only be issued while no request is in flight.
module stepper_trapezoid_pulse_engine_top
    import stpe_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic signed [POS_W-1:0] s_target,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_step_pulse,
    output logic                    m_direction,
    output logic signed [POS_W-1:0] m_position,
    output logic                    m_moving,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t         cfg_reg;
    step_result_t result;
    step_result_t out_reg;
    logic         m_valid_reg;
    logic         accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_per_tick     <= ACCEL_RESET;
            cfg_reg.max_speed_per_tick <= MAX_SPEED_RESET;
            cfg_reg.accel_distance     <= ACCEL_DIST_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_ACCEL_PER_TICK:     cfg_reg.accel_per_tick     <= cfg_data[RATE_W-1:0];
                CFG_MAX_SPEED_PER_TICK: cfg_reg.max_speed_per_tick <= cfg_data[RATE_W-1:0];
                CFG_ACCEL_DISTANCE:     cfg_reg.accel_distance     <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    stpe_motion #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_motion (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .kind    (s_kind),
        .target  (s_target),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_step_pulse = out_reg.step_pulse;
    assign m_direction  = out_reg.direction;
    assign m_position   = out_reg.position;
    assign m_moving     = out_reg.moving;

endmodule

[hdl/stpe_motion.sv]
// motion state and per-request ramp, accumulator and position update
module stpe_motion
    import stpe_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic                    kind,
    input  logic signed [POS_W-1:0] target,
    input  cfg_t                    cfg,
    output step_result_t            result
);

    localparam int ACC_W = FRACTION_BITS + 2;
    localparam int SUM_W = ((ACC_W > SPEED_W) ? ACC_W : SPEED_W) + 1;
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] STEP_UNIT = ACC_W'(1) << FRACTION_BITS;

    logic [POS_W-1:0]   cur_pos_reg, cur_pos_next;
    logic [POS_W-1:0]   goal_reg, goal_next;
    logic [POS_W-1:0]   decel_reg, decel_next;
    logic               dir_rev_reg, dir_rev_next;
    logic               motion_reg, motion_next;
    logic               in_decel_reg, in_decel_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;

    logic               pulse;
    logic [POS_W:0]     diff;
    logic [POS_W:0]     abs_diff;
    logic [POS_W-1:0]   half;
    logic [DIST_W-1:0]  back;
    logic [SPEED_W:0]   speed_sum;
    logic [SPEED_W:0]   speed_dec;
    logic [SUM_W-1:0]   acc_sum;
    logic [ACC_W-1:0]   acc_sat;

    always_comb begin
        cur_pos_next  = cur_pos_reg;
        goal_next     = goal_reg;
        decel_next    = decel_reg;
        dir_rev_next  = dir_rev_reg;
        motion_next   = motion_reg;
        in_decel_next = in_decel_reg;
        speed_next    = speed_reg;
        acc_next      = acc_reg;
        pulse         = 1'b0;

        diff = {target[POS_W-1], target} - {cur_pos_reg[POS_W-1], cur_pos_reg};
        abs_diff = diff[POS_W] ? (~diff + 1'b1) : diff;
        half = abs_diff[POS_W:1];
        back = ({1'b0, cfg.accel_distance} < half) ? cfg.accel_distance
                                                   : half[DIST_W-1:0];

        speed_sum = {1'b0, speed_reg} + {2'b00, cfg.accel_per_tick};
        speed_dec = {1'b0, speed_reg} - {2'b00, cfg.accel_per_tick};
        acc_sum   = '0;
        acc_sat   = acc_reg;

        if (kind) begin
            goal_next     = target;
            in_decel_next = 1'b0;
            speed_next    = '0;
            motion_next   = 1'b1;
            if (!diff[POS_W] && (diff != '0)) begin
                dir_rev_next = 1'b0;
                decel_next   = target - POS_W'(back);
            end else begin
                dir_rev_next = 1'b1;
                decel_next   = target + POS_W'(back);
            end
        end else if (motion_reg && (cur_pos_reg != goal_reg)) begin
            in_decel_next = in_decel_reg | (cur_pos_reg == decel_reg);
            if (!in_decel_next) begin
                if (speed_reg < {1'b0, cfg.max_speed_per_tick}) begin
                    speed_next = speed_sum[SPEED_W-1:0];
                end
            end else begin
                if (speed_dec[SPEED_W] || (speed_dec == '0)) begin
                    speed_next = {1'b0, cfg.accel_per_tick};
                end else begin
                    speed_next = speed_dec[SPEED_W-1:0];
                end
            end
            acc_sum = SUM_W'(acc_reg) + SUM_W'(speed_next);
            acc_sat = (acc_sum > SUM_W'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
            acc_next = acc_sat;
            if (acc_sat > STEP_UNIT) begin
                pulse        = 1'b1;
                cur_pos_next = dir_rev_reg ? (cur_pos_reg - 1'b1)
                                           : (cur_pos_reg + 1'b1);
                acc_next     = acc_sat - STEP_UNIT;
            end
        end else begin
            motion_next = 1'b0;
        end

        result.step_pulse = pulse;
        result.direction  = dir_rev_next;
        result.position   = cur_pos_next;
        result.moving     = motion_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_pos_reg  <= '0;
            goal_reg     <= '0;
            decel_reg    <= '0;
            dir_rev_reg  <= 1'b0;
            motion_reg   <= 1'b0;
            in_decel_reg <= 1'b0;
            speed_reg    <= '0;
            acc_reg      <= '0;
        end else if (accept) begin
            cur_pos_reg  <= cur_pos_next;
            goal_reg     <= goal_next;
            decel_reg    <= decel_next;
            dir_rev_reg  <= dir_rev_next;
            motion_reg   <= motion_next;
            in_decel_reg <= in_decel_next;
            speed_reg    <= speed_next;
            acc_reg      <= acc_next;
        end
    end

endmodule
